/* design/key_tap_hold_classifier_macros.svh */
// assertion helpers shared by the classifier modules
// every module that uses them has clk and rst_n in scope
`ifndef KEY_TAP_HOLD_CLASSIFIER_MACROS_SVH
`define KEY_TAP_HOLD_CLASSIFIER_MACROS_SVH

// same-cycle implication, quiet while in reset
`define KTHC_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while in reset
`define KTHC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/kthc_pkg.sv */
package kthc_pkg;

    localparam int NUM_KEYS_DEF  = 256;
    localparam int TIME_BITS_DEF = 32;

    localparam int KEY_W     = 8;
    localparam int ELAPSED_W = 16;
    localparam int THR_W     = 32;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd100;

    // result queue depth, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HELD     = 2'd2,
        ST_RELEASED = 2'd3
    } key_state_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_TAP    = 2'd1,
        EV_HELD   = 2'd2,
        EV_UNHOLD = 2'd3
    } key_event_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_id;
        key_event_t       event_res;
        key_state_t       new_state;
    } result_t;

endpackage

/* design/kthc_front.sv */
`include "key_tap_hold_classifier_macros.svh"

module kthc_front #(
    parameter int NUM_KEYS  = kthc_pkg::NUM_KEYS_DEF,
    parameter int TIME_BITS = kthc_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [kthc_pkg::THR_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [kthc_pkg::ELAPSED_W-1:0] elapsed,
    input  logic [kthc_pkg::KEY_W-1:0]   key_code,
    input  logic                         pressed,
    input  logic [kthc_pkg::QCNT_W-1:0]  q_count,
    output logic                         push_valid,
    output kthc_pkg::result_t            push_data
);

    localparam int IDX_W = $clog2(NUM_KEYS);
    localparam int EXT_W = ((IDX_W > kthc_pkg::KEY_W) ? IDX_W : kthc_pkg::KEY_W) + 1;
    localparam int CMP_W = (TIME_BITS > kthc_pkg::THR_W) ? TIME_BITS : kthc_pkg::THR_W;
    localparam int CRD_W = kthc_pkg::QCNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYS - 1);

    // key tables
    kthc_pkg::key_state_t     key_state_mem [NUM_KEYS];
    logic [TIME_BITS-1:0]     press_time_mem [NUM_KEYS];

    logic                     clearing_reg;
    logic [IDX_W-1:0]         clr_idx_reg;
    logic [TIME_BITS-1:0]     time_now_reg, time_now_next;
    logic [kthc_pkg::THR_W-1:0] threshold_reg;

    // classify stage
    logic                     s1_valid_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic [kthc_pkg::KEY_W-1:0] s1_key_reg;
    logic                     s1_pressed_reg;
    logic [TIME_BITS-1:0]     s1_time_reg;
    kthc_pkg::key_state_t     st_rd_reg;
    logic [TIME_BITS-1:0]     pt_rd_reg;

    // forward of the entry written by the previous sample
    logic                     byp_reg, byp_next;
    kthc_pkg::key_state_t     byp_state_reg;
    logic [TIME_BITS-1:0]     byp_ptime_reg;

    logic [EXT_W-1:0]         key_ext;
    logic                     in_range;
    logic [IDX_W-1:0]         idx_in;
    logic                     accept, time_acc, key_acc;

    kthc_pkg::key_state_t     from_state, to_state;
    kthc_pkg::key_event_t     ev;
    logic [TIME_BITS-1:0]     cur_ptime, age, ptime_after;
    logic                     age_hit, stamp;

    logic                     st_we;
    logic [IDX_W-1:0]         st_wa;
    kthc_pkg::key_state_t     st_wd;

    assign key_ext  = EXT_W'(key_code);
    assign in_range = key_ext < EXT_W'(NUM_KEYS);
    assign idx_in   = key_ext[IDX_W-1:0];

    // room for every sample in flight keeps the queue from overflowing
    assign in_ready = !clearing_reg &&
                      ((CRD_W'(q_count) + CRD_W'(s1_valid_reg)) < CRD_W'(kthc_pkg::QUEUE_DEPTH));
    assign accept   = in_valid && in_ready;
    assign time_acc = accept && !op;
    assign key_acc  = accept && op && in_range;

    assign time_now_next = time_now_reg + TIME_BITS'(elapsed);

    assign from_state = byp_reg ? byp_state_reg : st_rd_reg;
    assign cur_ptime  = byp_reg ? byp_ptime_reg : pt_rd_reg;
    assign age        = s1_time_reg - cur_ptime;
    assign age_hit    = CMP_W'(age) >= CMP_W'(threshold_reg);

    always_comb
    begin
        to_state = from_state;
        stamp    = 1'b0;
        if (s1_pressed_reg)
        begin
            case (from_state)
                kthc_pkg::ST_FREE, kthc_pkg::ST_RELEASED:
                begin
                    to_state = kthc_pkg::ST_PRESSED;
                    stamp    = 1'b1;
                end
                kthc_pkg::ST_PRESSED:
                begin
                    if (age_hit)
                    begin
                        to_state = kthc_pkg::ST_HELD;
                    end
                end
                default: to_state = from_state;
            endcase
        end
        else
        begin
            case (from_state)
                kthc_pkg::ST_PRESSED, kthc_pkg::ST_HELD: to_state = kthc_pkg::ST_RELEASED;
                default:                                 to_state = from_state;
            endcase
        end
    end

    always_comb
    begin
        ev = kthc_pkg::EV_NONE;
        case (from_state)
            kthc_pkg::ST_PRESSED:
            begin
                if (to_state == kthc_pkg::ST_RELEASED)
                begin
                    ev = kthc_pkg::EV_TAP;
                end
                else if (to_state == kthc_pkg::ST_HELD)
                begin
                    ev = kthc_pkg::EV_HELD;
                end
            end
            kthc_pkg::ST_HELD:
            begin
                if (to_state == kthc_pkg::ST_HELD)
                begin
                    ev = kthc_pkg::EV_HELD;
                end
                else if (to_state == kthc_pkg::ST_RELEASED)
                begin
                    ev = kthc_pkg::EV_UNHOLD;
                end
            end
            default: ev = kthc_pkg::EV_NONE;
        endcase
    end

    assign ptime_after = stamp ? s1_time_reg : cur_ptime;

    assign push_valid          = s1_valid_reg;
    assign push_data.key_id    = s1_key_reg;
    assign push_data.event_res = ev;
    assign push_data.new_state = to_state;

    // one write port, shared by the clearing sweep and the classify stage
    assign st_we = clearing_reg || s1_valid_reg;
    assign st_wa = clearing_reg ? clr_idx_reg : s1_idx_reg;
    assign st_wd = clearing_reg ? kthc_pkg::ST_FREE : to_state;

    assign byp_next = s1_valid_reg && (s1_idx_reg == idx_in);

    always_ff @(posedge clk)
    begin
        if (key_acc)
        begin
            st_rd_reg <= key_state_mem[idx_in];
            pt_rd_reg <= press_time_mem[idx_in];
        end
        if (st_we)
        begin
            key_state_mem[st_wa] <= st_wd;
        end
        if (s1_valid_reg && stamp)
        begin
            press_time_mem[s1_idx_reg] <= s1_time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            time_now_reg  <= '0;
            threshold_reg <= kthc_pkg::THRESHOLD_RESET;
            s1_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_we)
            begin
                threshold_reg <= cfg_data;
            end
            if (time_acc)
            begin
                time_now_reg <= time_now_next;
            end
            s1_valid_reg <= key_acc;
            if (key_acc)
            begin
                byp_reg <= byp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_acc)
        begin
            s1_idx_reg     <= idx_in;
            s1_key_reg     <= key_code;
            s1_pressed_reg <= pressed;
            s1_time_reg    <= time_now_reg;
            byp_state_reg  <= to_state;
            byp_ptime_reg  <= ptime_after;
        end
    end

    `KTHC_CHECK(a_queue_room, s1_valid_reg, q_count < kthc_pkg::QCNT_W'(kthc_pkg::QUEUE_DEPTH), "result pushed into a full queue")
    `KTHC_CHECK(a_bypass_source, byp_reg && s1_valid_reg, $past(s1_valid_reg), "forward taken with no sample ahead")
    `KTHC_CHECK(a_clear_span, $fell(clearing_reg), $past(clr_idx_reg) == LAST_IDX, "clearing sweep ended early")

endmodule

/* design/kthc_queue.sv */
`include "key_tap_hold_classifier_macros.svh"

module kthc_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  kthc_pkg::result_t           push_data,
    input  logic                        pop,
    output logic                        pop_valid,
    output kthc_pkg::result_t           pop_data,
    output logic [kthc_pkg::QCNT_W-1:0] count
);

    kthc_pkg::result_t              entry_reg [kthc_pkg::QUEUE_DEPTH];
    logic [kthc_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [kthc_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `KTHC_CHECK(a_no_pop_empty, pop, count_reg != '0, "pop from an empty result queue")

endmodule

/* design/kthc_back.sv */
module kthc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  kthc_pkg::result_t q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output kthc_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    kthc_pkg::result_t out_data_reg;

    // refill the output register whenever it is empty or being taken
    assign q_pop          = q_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = q_pop || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= q_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/key_tap_hold_classifier.sv */
// per-key tap / hold classifier
// input channel (in_valid / in_ready): each request is either a time advance
//   (op = 0, elapsed ticks added to a wrapping time counter) or a key sample
//   (op = 1, key_code and pressed level); time advances and samples of keys
//   outside the table give no result
// output channel (out_valid / out_ready): one result per in-range key sample,
//   key_id, event_res (none, tap, held, released from hold) and new_state
// configuration: cfg_we writes cfg_data into the hold threshold, reset 100
// throughput: one request per cycle while in_ready is high, set by the single
//   read-modify-write of the key tables and the one-entry forward that covers
//   back-to-back samples of the same key
// path: the edge that takes a sample also reads the key tables; the sample is then
//   classified and pushed into the queue, and the result shows on out_valid once
//   it is loaded into the output register
// reset: the key state table is swept to free, one entry a cycle, so
//   in_ready stays low after rst_n rises until every entry is swept; cfg writes are
//   taken during the sweep
// stall: a stalled receiver fills the output register and then the 4-entry
//   result queue; in_ready drops once the queue has no room left for samples
//   already in flight, and nothing is lost
module key_tap_hold_classifier #(
    parameter int NUM_KEYS  = kthc_pkg::NUM_KEYS_DEF,
    parameter int TIME_BITS = kthc_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // threshold register write
    input  logic                           cfg_we,
    input  logic [kthc_pkg::THR_W-1:0]     cfg_data,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [kthc_pkg::ELAPSED_W-1:0] elapsed,
    input  logic [kthc_pkg::KEY_W-1:0]     key_code,
    input  logic                           pressed,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [kthc_pkg::KEY_W-1:0]     key_id,
    output logic [1:0]                     event_res,
    output logic [1:0]                     new_state
);

    // front to queue
    logic                        push_valid;
    kthc_pkg::result_t           push_data;
    logic [kthc_pkg::QCNT_W-1:0] q_count;

    // queue to back
    logic                        q_valid;
    logic                        q_pop;
    kthc_pkg::result_t           q_data;

    kthc_pkg::result_t           out_data;

    // classification, time counter, key tables and threshold
    kthc_front #(
        .NUM_KEYS  (NUM_KEYS),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .elapsed    (elapsed),
        .key_code   (key_code),
        .pressed    (pressed),
        .q_count    (q_count),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // short queue that lets the front run while the receiver stalls
    kthc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .count     (q_count)
    );

    // registered output stage
    kthc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign key_id    = out_data.key_id;
    assign event_res = out_data.event_res;
    assign new_state = out_data.new_state;

endmodule
